// File: hw/rtl/lrb_pkg.sv
// Package for the link reconnect backoff controller.
// Holds the event, mode, notify, failure and register codes and the shared structs.
// No dependencies.
`default_nettype none

package lrb_pkg;

  typedef enum logic [2:0] {
    OP_INIT             = 3'd0,
    OP_STA_START        = 3'd1,
    OP_GOT_IP           = 3'd2,
    OP_TIMER_FIRED      = 3'd3,
    OP_RECONFIG_TIMEOUT = 3'd4,
    OP_PROVISIONED      = 3'd5,
    OP_DISCONNECTED     = 3'd6,
    OP_ACTION_FAILED    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    MODE_DISC       = 3'd0,
    MODE_CONNECTING = 3'd1,
    MODE_CONNECTED  = 3'd2,
    MODE_RECONF     = 3'd3,
    MODE_STOPPED    = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    NOTE_DISC = 2'd0,
    NOTE_CONN = 2'd1,
    NOTE_PROV = 2'd2,
    NOTE_STOP = 2'd3
  } note_e;

  typedef enum logic [1:0] {
    FAIL_CONNECT    = 2'd0,
    FAIL_DISCONNECT = 2'd1,
    FAIL_TIMER      = 2'd2
  } fail_e;

  typedef enum logic [1:0] {
    CFG_BACKOFF_BASE = 2'd0,
    CFG_BACKOFF_MAX  = 2'd1,
    CFG_AUTH_LIMIT   = 2'd2
  } cfg_idx_e;

  localparam int unsigned BaseW  = 16;
  localparam int unsigned DelayW = 22;
  localparam int unsigned CntW   = 8;
  localparam int unsigned GenW   = 32;
  localparam int unsigned ReasonW = 8;

  localparam logic [BaseW-1:0]  BaseReset  = 16'd1000;
  localparam logic [DelayW-1:0] MaxReset   = 22'd60000;
  localparam logic [CntW-1:0]   LimitReset = 8'd3;
  localparam logic [CntW-1:0]   CntMax     = 8'd255;
  localparam logic [CntW-1:0]   ShiftAttempts = 8'd6;

  // Disconnect reasons that count as authentication failures
  localparam logic [ReasonW-1:0] ReasonAuthA = 8'd202;
  localparam logic [ReasonW-1:0] ReasonAuthB = 8'd15;
  localparam logic [ReasonW-1:0] ReasonAuthC = 8'd204;
  localparam logic [ReasonW-1:0] ReasonAuthD = 8'd14;
  localparam logic [ReasonW-1:0] ReasonAuthE = 8'd23;

  typedef struct packed {
    logic [BaseW-1:0]  backoff_base;
    logic [DelayW-1:0] backoff_max;
    logic [CntW-1:0]   auth_limit;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [CntW-1:0]   retry_cnt;
    logic [CntW-1:0]   auth_cnt;
    logic              provisioned;
    logic              timer_run;
    logic [GenW-1:0]   timer_tag;
  } state_t;

  typedef struct packed {
    logic              accepted;
    logic              do_connect;
    logic              do_disconnect;
    logic              do_start_timer;
    logic              do_stop_timer;
    logic              do_notify;
    note_e             notify_code;
    logic [DelayW-1:0] delay_ms;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/lrb_cfg_regs.sv
// Configuration registers of the link reconnect backoff controller.
// Depends on lrb_pkg for the register index codes and cfg_t.
`default_nettype none

module lrb_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr_en_i,
  input  wire logic [1:0]                 wr_index_i,
  input  wire logic [lrb_pkg::DelayW-1:0] wr_data_i,
  output lrb_pkg::cfg_t                   cfg_o
);

  lrb_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        lrb_pkg::CFG_BACKOFF_BASE: cfg_d.backoff_base = wr_data_i[lrb_pkg::BaseW-1:0];
        lrb_pkg::CFG_BACKOFF_MAX:  cfg_d.backoff_max  = wr_data_i;
        lrb_pkg::CFG_AUTH_LIMIT:   cfg_d.auth_limit   = wr_data_i[lrb_pkg::CntW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff_base <= lrb_pkg::BaseReset;
      cfg_q.backoff_max  <= lrb_pkg::MaxReset;
      cfg_q.auth_limit   <= lrb_pkg::LimitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/lrb_step.sv
// Next-state and result logic for one event of the reconnect controller.
// Purely combinational; depends on lrb_pkg for codes and structs.
`default_nettype none

module lrb_step (
  input  wire logic [2:0]                  operation_i,
  input  wire logic                        saved_creds_i,
  input  wire logic [lrb_pkg::GenW-1:0]    event_generation_i,
  input  wire logic [lrb_pkg::ReasonW-1:0] drop_cause_i,
  input  wire logic [1:0]                  fail_kind_i,
  input  wire lrb_pkg::cfg_t               cfg_i,
  input  wire lrb_pkg::state_t             st_i,
  output lrb_pkg::state_t                  st_o,
  output lrb_pkg::res_t                    res_o
);

  logic                          reason_auth;
  logic [lrb_pkg::CntW-1:0]      retry_inc;
  logic [lrb_pkg::CntW-1:0]      auth_inc;
  logic [lrb_pkg::DelayW-1:0]    base_ext;
  logic [lrb_pkg::DelayW-1:0]    backoff_delay;

  assign reason_auth = (drop_cause_i == lrb_pkg::ReasonAuthA) ||
                       (drop_cause_i == lrb_pkg::ReasonAuthB) ||
                       (drop_cause_i == lrb_pkg::ReasonAuthC) ||
                       (drop_cause_i == lrb_pkg::ReasonAuthD) ||
                       (drop_cause_i == lrb_pkg::ReasonAuthE);

  assign retry_inc = (st_i.retry_cnt == lrb_pkg::CntMax) ? st_i.retry_cnt
                                                         : st_i.retry_cnt + 8'd1;
  assign auth_inc  = (st_i.auth_cnt == lrb_pkg::CntMax) ? st_i.auth_cnt
                                                        : st_i.auth_cnt + 8'd1;

  // Attempt after an arm is retry_inc, at least 1; attempts above six use the cap.
  assign base_ext = {{(lrb_pkg::DelayW - lrb_pkg::BaseW){1'b0}}, cfg_i.backoff_base};
  assign backoff_delay = (retry_inc > lrb_pkg::ShiftAttempts) ? cfg_i.backoff_max
                       : (base_ext << (retry_inc[2:0] - 3'd1));

  always_comb begin
    st_o  = st_i;
    res_o = '0;

    unique case (lrb_pkg::op_e'(operation_i))
      lrb_pkg::OP_INIT: begin
        st_o             = '0;
        st_o.mode        = lrb_pkg::MODE_DISC;
        st_o.provisioned = saved_creds_i;
        res_o.accepted   = 1'b1;
      end

      lrb_pkg::OP_STA_START: begin
        if (saved_creds_i) begin
          st_o.provisioned = 1'b1;
          st_o.mode        = lrb_pkg::MODE_CONNECTING;
          res_o.do_connect = 1'b1;
          res_o.accepted   = 1'b1;
        end
      end

      lrb_pkg::OP_GOT_IP: begin
        st_o.mode          = lrb_pkg::MODE_CONNECTED;
        st_o.retry_cnt     = '0;
        st_o.auth_cnt      = '0;
        st_o.timer_run     = 1'b0;
        res_o.do_stop_timer = st_i.timer_run;
        res_o.do_notify    = 1'b1;
        res_o.notify_code  = lrb_pkg::NOTE_CONN;
        res_o.accepted     = 1'b1;
      end

      lrb_pkg::OP_TIMER_FIRED: begin
        // Stale generations are ignored outright
        if (event_generation_i == st_i.timer_tag) begin
          st_o.timer_run = 1'b0;
          if (st_i.mode == lrb_pkg::MODE_DISC && st_i.provisioned) begin
            st_o.mode        = lrb_pkg::MODE_CONNECTING;
            res_o.do_connect = 1'b1;
            res_o.accepted   = 1'b1;
          end
        end
      end

      lrb_pkg::OP_RECONFIG_TIMEOUT: begin
        if (st_i.mode == lrb_pkg::MODE_RECONF) begin
          st_o.mode        = lrb_pkg::MODE_CONNECTING;
          res_o.do_connect = 1'b1;
          res_o.accepted   = 1'b1;
        end
      end

      lrb_pkg::OP_PROVISIONED: begin
        st_o.provisioned    = 1'b1;
        st_o.retry_cnt      = '0;
        st_o.auth_cnt       = '0;
        st_o.timer_run      = 1'b0;
        res_o.do_stop_timer = st_i.timer_run;
        if (st_i.mode == lrb_pkg::MODE_DISC || st_i.mode == lrb_pkg::MODE_STOPPED) begin
          st_o.mode        = lrb_pkg::MODE_CONNECTING;
          res_o.do_connect = 1'b1;
        end else begin
          st_o.mode           = lrb_pkg::MODE_RECONF;
          res_o.do_disconnect = 1'b1;
        end
        res_o.do_notify   = 1'b1;
        res_o.notify_code = lrb_pkg::NOTE_PROV;
        res_o.accepted    = 1'b1;
      end

      lrb_pkg::OP_DISCONNECTED: begin
        if (st_i.mode == lrb_pkg::MODE_RECONF) begin
          st_o.mode        = lrb_pkg::MODE_CONNECTING;
          res_o.do_connect = 1'b1;
          res_o.accepted   = 1'b1;
        end else if (st_i.mode != lrb_pkg::MODE_STOPPED) begin
          res_o.accepted      = 1'b1;
          res_o.do_stop_timer = st_i.timer_run;
          res_o.do_notify     = 1'b1;
          res_o.notify_code   = lrb_pkg::NOTE_DISC;
          st_o.mode           = lrb_pkg::MODE_DISC;
          st_o.timer_run      = 1'b0;
          if (reason_auth) begin
            st_o.auth_cnt = auth_inc;
          end
          if (reason_auth && (auth_inc >= cfg_i.auth_limit)) begin
            st_o.mode         = lrb_pkg::MODE_STOPPED;
            res_o.notify_code = lrb_pkg::NOTE_STOP;
          end else begin
            st_o.retry_cnt       = retry_inc;
            st_o.timer_run       = 1'b1;
            st_o.timer_tag       = st_i.timer_tag + 32'd1;
            res_o.do_start_timer = 1'b1;
            res_o.delay_ms       = backoff_delay;
          end
        end
      end

      lrb_pkg::OP_ACTION_FAILED: begin
        case (fail_kind_i)
          lrb_pkg::FAIL_CONNECT: begin
            if (st_i.mode == lrb_pkg::MODE_CONNECTING) begin
              st_o.mode            = lrb_pkg::MODE_DISC;
              st_o.retry_cnt       = retry_inc;
              st_o.timer_run       = 1'b1;
              st_o.timer_tag       = st_i.timer_tag + 32'd1;
              res_o.do_start_timer = 1'b1;
              res_o.delay_ms       = backoff_delay;
              res_o.accepted       = 1'b1;
            end
          end
          lrb_pkg::FAIL_DISCONNECT: begin
            if (st_i.mode == lrb_pkg::MODE_RECONF) begin
              st_o.mode        = lrb_pkg::MODE_CONNECTING;
              res_o.do_connect = 1'b1;
              res_o.accepted   = 1'b1;
            end
          end
          lrb_pkg::FAIL_TIMER: st_o.timer_run = 1'b0;
          default: ;  // unused kind: no change
        endcase
      end

      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/link_reconnect_backoff_fsm_top.sv
// Top level of the link reconnect backoff controller.
// Instantiates lrb_cfg_regs and lrb_step; depends on lrb_pkg.
`default_nettype none

// One event beat is taken every cycle while the input register is free or
// its event can advance. Each beat lands in an input register and is
// processed against the controller state once the result register is free
// or draining, and its result is then registered. Input ready follows
// out_ready_i combinationally when both registers are full; a waiting result
// does not block a new event from entering an empty input register.
// Configuration writes are always ready and take effect on the next cycle.
module link_reconnect_backoff_fsm_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  operation_i,
  input  wire logic        saved_creds_i,
  input  wire logic [31:0] event_generation_i,
  input  wire logic [7:0]  drop_cause_i,
  input  wire logic [1:0]  fail_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             accepted_o,
  output logic             do_connect_o,
  output logic             do_disconnect_o,
  output logic             do_start_timer_o,
  output logic             do_stop_timer_o,
  output logic             do_notify_o,
  output logic [1:0]       notify_code_o,
  output logic [21:0]      delay_ms_o,
  output logic [31:0]      current_generation_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [21:0] cfg_data_i
);

  lrb_pkg::cfg_t   cfg;
  lrb_pkg::state_t st_q, st_d;
  lrb_pkg::res_t   res_d, res_q;

  logic        in_valid_q;
  logic [2:0]  op_q;
  logic        creds_q;
  logic [31:0] gen_q;
  logic [7:0]  reason_q;
  logic [1:0]  kind_q;
  logic        out_valid_q;
  logic [31:0] out_gen_q;
  logic        advance;

  assign cfg_ready_o = 1'b1;

  lrb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Process the held event when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q     <= operation_i;
      creds_q  <= saved_creds_i;
      gen_q    <= event_generation_i;
      reason_q <= drop_cause_i;
      kind_q   <= fail_kind_i;
    end
  end

  lrb_step u_step (
    .operation_i         (op_q),
    .saved_creds_i       (creds_q),
    .event_generation_i  (gen_q),
    .drop_cause_i        (reason_q),
    .fail_kind_i         (kind_q),
    .cfg_i               (cfg),
    .st_i                (st_q),
    .st_o                (st_d),
    .res_o               (res_d)
  );

  // Reset state is all zero, which is also the disconnected mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q     <= res_d;
      out_gen_q <= st_d.timer_tag;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign accepted_o           = res_q.accepted;
  assign do_connect_o         = res_q.do_connect;
  assign do_disconnect_o      = res_q.do_disconnect;
  assign do_start_timer_o     = res_q.do_start_timer;
  assign do_stop_timer_o      = res_q.do_stop_timer;
  assign do_notify_o          = res_q.do_notify;
  assign notify_code_o        = res_q.notify_code;
  assign delay_ms_o           = res_q.delay_ms;
  assign current_generation_o = out_gen_q;

  // Result register and controller state move together
  a_gen_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_gen_q == st_q.timer_tag))
    else $error("result generation differs from stored timer tag");

  a_start_arms_timer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.do_start_timer) |-> st_q.timer_run)
    else $error("timer started but not marked running");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed event left no result");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == lrb_pkg::OP_INIT) |=>
      (res_q.accepted && out_gen_q == 32'd0 && st_q.retry_cnt == 8'd0))
    else $error("init event did not clear state");

endmodule

`default_nettype wire
